>>> hw/rtl/nearest_site_labeler_unit_defines.svh
// ----------------------------------------------------------------------------
// Nearest site labeler assertion macros
// Shared concurrent assertion wrappers for the labeler RTL.
// ----------------------------------------------------------------------------
`ifndef NEAREST_SITE_LABELER_UNIT_DEFINES_SVH
`define NEAREST_SITE_LABELER_UNIT_DEFINES_SVH

// Assert a property on an explicit clock and active-low reset.
`define NSL_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the block clock and reset.
`define NSL_ASSERT(label, prop, msg) \
  `NSL_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

// Assert that a condition never holds.
`define NSL_ASSERT_NEVER(label, cond, msg) \
  `NSL_ASSERT(label, !(cond), msg)

`endif

>>> hw/rtl/nsl_pkg.sv
// ----------------------------------------------------------------------------
// Nearest site labeler package
// Sizes, site and tag types, and operation codes shared by the labeler RTL.
// ----------------------------------------------------------------------------
package nsl_pkg;

  // Table and coordinate sizes
  localparam int MAX_SITES  = 32;
  localparam int COORD_BITS = 10;

  // Fixed field widths of the ports
  localparam int SLOT_IN_BITS = 5;
  localparam int IDX_OUT_BITS = 5;
  localparam int CFG_BITS     = 6;

  // Derived sizes
  localparam int SLOT_BITS     = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int CNT_BITS      = $clog2(MAX_SITES + 1);
  localparam int CMP_BITS      = (CFG_BITS > CNT_BITS) ? CFG_BITS : CNT_BITS;
  localparam int SLOT_CMP_BITS = (SLOT_IN_BITS > CNT_BITS) ? SLOT_IN_BITS : CNT_BITS;
  localparam int SQ_BITS       = 2 * COORD_BITS;
  localparam int DIST_BITS     = SQ_BITS + 1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } nsl_op_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } nsl_site_t;

  localparam int SITE_BITS = $bits(nsl_site_t);

  // Control tag that travels alongside each site through the distance pipe
  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic [SLOT_BITS-1:0] idx;
  } nsl_tag_t;

endpackage

>>> hw/rtl/nsl_site_ram.sv
// ----------------------------------------------------------------------------
// Site table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nsl_site_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 20
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/nsl_dist_pipe.sv
// ----------------------------------------------------------------------------
// Squared distance pipe
// Three-stage pipe: absolute differences, squares, sum. Tag rides along.
// ----------------------------------------------------------------------------
module nsl_dist_pipe (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nsl_pkg::nsl_tag_t                 tag_i,
  input  nsl_pkg::nsl_site_t                site_i,
  input  logic [nsl_pkg::COORD_BITS-1:0]    px_i,
  input  logic [nsl_pkg::COORD_BITS-1:0]    py_i,
  output nsl_pkg::nsl_tag_t                 tag_o,
  output logic [nsl_pkg::DIST_BITS-1:0]     dist_o
);

  nsl_pkg::nsl_tag_t tag1_q, tag2_q, tag3_q;

  logic [nsl_pkg::COORD_BITS-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [nsl_pkg::SQ_BITS-1:0]    sqx_d, sqy_d, sqx_q, sqy_q;
  logic [nsl_pkg::DIST_BITS-1:0]  dist_d, dist_q;

  always_comb begin
    dx_d   = (px_i > site_i.x) ? (px_i - site_i.x) : (site_i.x - px_i);
    dy_d   = (py_i > site_i.y) ? (py_i - site_i.y) : (site_i.y - py_i);
    sqx_d  = nsl_pkg::SQ_BITS'(dx_q) * nsl_pkg::SQ_BITS'(dx_q);
    sqy_d  = nsl_pkg::SQ_BITS'(dy_q) * nsl_pkg::SQ_BITS'(dy_q);
    dist_d = nsl_pkg::DIST_BITS'(sqx_q) + nsl_pkg::DIST_BITS'(sqy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    dist_q <= dist_d;
  end

  assign tag_o  = tag3_q;
  assign dist_o = dist_q;

endmodule

>>> hw/rtl/nearest_site_labeler_unit.sv
// ----------------------------------------------------------------------------
// Nearest site labeler
// Discrete Voronoi labeling by Euclidean nearest site. A load word (op = 0)
// writes site (coord_x, coord_y) into the site table at slot; it gives no
// result and is accepted even while an earlier result
// still waits on the output. A query word (op = 1) gives a pixel; the block
// scans slots 0 to num_generators - 1 (capped at the table size), computes
// exact squared distances dx*dx + dy*dy, and returns the index of the least
// one, the lowest index winning ties. With no sites taking part the result
// is index 0 with none_loaded set. A query holds the block until its result
// enters the output register; the site table is read one entry per cycle and
// each read feeds a three-stage distance pipe, so the table read port sets the rate.
// Slots read by a query must have been loaded since reset. The user must
// write num_generators through the cfg channel while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "nearest_site_labeler_unit_defines.svh"

module nearest_site_labeler_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nsl_pkg::CFG_BITS-1:0]        cfg_data_i,
  // Input words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic [nsl_pkg::SLOT_IN_BITS-1:0]    slot_i,
  input  logic [nsl_pkg::COORD_BITS-1:0]      coord_x_i,
  input  logic [nsl_pkg::COORD_BITS-1:0]      coord_y_i,
  // Result words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [nsl_pkg::IDX_OUT_BITS-1:0]    nearest_index_o,
  output logic                                none_loaded_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;

  logic [nsl_pkg::CFG_BITS-1:0]  num_gen_q, num_gen_d;
  logic [nsl_pkg::CNT_BITS-1:0]  count_q, count_d;
  logic [nsl_pkg::SLOT_BITS-1:0] k_q, k_d;
  logic [nsl_pkg::COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic [nsl_pkg::DIST_BITS-1:0] best_dist_q, best_dist_d;
  logic [nsl_pkg::SLOT_BITS-1:0] best_idx_q, best_idx_d;
  logic                          none_q, none_d;
  logic                          out_valid_q, out_valid_d;
  logic [nsl_pkg::SLOT_BITS-1:0] out_idx_q, out_idx_d;
  logic                          out_none_q, out_none_d;
  nsl_pkg::nsl_tag_t             iss_tag_q, iss_tag_d;

  logic                          in_fire;
  logic                          slot_ok;
  logic                          ram_we;
  logic [nsl_pkg::CMP_BITS-1:0]  cfg_ext;
  logic [nsl_pkg::CNT_BITS-1:0]  count_sat;
  logic [nsl_pkg::SITE_BITS-1:0] ram_rdata;
  nsl_pkg::nsl_site_t            wr_site;
  nsl_pkg::nsl_site_t            rd_site;
  nsl_pkg::nsl_tag_t             d_tag;
  logic [nsl_pkg::DIST_BITS-1:0] d_dist;
  logic                          out_free;

  // Accept words only between queries; loads complete at acceptance.
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign slot_ok = (nsl_pkg::SLOT_CMP_BITS'(slot_i) < nsl_pkg::SLOT_CMP_BITS'(nsl_pkg::MAX_SITES));
  assign ram_we  = in_fire && (op_i == nsl_pkg::OP_LOAD) && slot_ok;
  assign wr_site = '{x: coord_x_i, y: coord_y_i};

  // Cap the site count at the table size.
  assign cfg_ext   = nsl_pkg::CMP_BITS'(num_gen_q);
  assign count_sat = (cfg_ext > nsl_pkg::CMP_BITS'(nsl_pkg::MAX_SITES)) ?
                     nsl_pkg::CNT_BITS'(nsl_pkg::MAX_SITES) : nsl_pkg::CNT_BITS'(cfg_ext);

  // Output register frees when empty or when its word leaves this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  nsl_site_ram #(
    .DEPTH (nsl_pkg::MAX_SITES),
    .WIDTH (nsl_pkg::SITE_BITS)
  ) u_site_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (nsl_pkg::SLOT_BITS'(slot_i)),
    .wdata_i (wr_site),
    .re_i    (state_q == ST_SCAN),
    .raddr_i (k_q),
    .rdata_o (ram_rdata)
  );

  assign rd_site = nsl_pkg::nsl_site_t'(ram_rdata);

  // Tag registered on issue lines up with the RAM read data.
  nsl_dist_pipe u_dist_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (iss_tag_q),
    .site_i (rd_site),
    .px_i   (px_q),
    .py_i   (py_q),
    .tag_o  (d_tag),
    .dist_o (d_dist)
  );

  always_comb begin
    state_d     = state_q;
    num_gen_d   = num_gen_q;
    count_d     = count_q;
    k_d         = k_q;
    px_d        = px_q;
    py_d        = py_q;
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    none_d      = none_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_none_d  = out_none_q;
    iss_tag_d   = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      num_gen_d = cfg_data_i;
    end

    // Drop the pending result once taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Keep the running minimum; strict less keeps the lowest index on ties.
    if (d_tag.vld) begin
      if ((d_tag.idx == '0) || (d_dist < best_dist_q)) begin
        best_dist_d = d_dist;
        best_idx_d  = d_tag.idx;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (op_i == nsl_pkg::OP_QUERY)) begin
          px_d    = coord_x_i;
          py_d    = coord_y_i;
          count_d = count_sat;
          k_d     = '0;
          if (count_sat == '0) begin
            none_d  = 1'b1;
            state_d = ST_RESULT;
          end else begin
            none_d  = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue one table read per cycle.
        iss_tag_d.vld  = 1'b1;
        iss_tag_d.idx  = k_q;
        iss_tag_d.last = ((nsl_pkg::CNT_BITS'(k_q) + nsl_pkg::CNT_BITS'(1)) == count_q);
        k_d            = k_q + 1'b1;
        if (iss_tag_d.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (d_tag.vld && d_tag.last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = none_q ? '0 : best_idx_q;
          out_none_d  = none_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_gen_q   <= '0;
      count_q     <= '0;
      k_q         <= '0;
      none_q      <= 1'b0;
      out_valid_q <= 1'b0;
      iss_tag_q   <= '0;
    end else begin
      state_q     <= state_d;
      num_gen_q   <= num_gen_d;
      count_q     <= count_d;
      k_q         <= k_d;
      none_q      <= none_d;
      out_valid_q <= out_valid_d;
      iss_tag_q   <= iss_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q        <= px_d;
    py_q        <= py_d;
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
    out_idx_q   <= out_idx_d;
    out_none_q  <= out_none_d;
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = nsl_pkg::IDX_OUT_BITS'(out_idx_q);
  assign none_loaded_o   = out_none_q;

  // Distances come out of the pipe only while a query is in flight.
  `NSL_ASSERT(a_tag_in_query, d_tag.vld |-> (state_q == ST_SCAN || state_q == ST_DRAIN), "distance word outside a query")

  // Every scanned index stays below the site count.
  `NSL_ASSERT(a_scan_in_range, (state_q == ST_SCAN) |-> (nsl_pkg::CNT_BITS'(k_q) < count_q), "scan index beyond site count")

  // A result handed to a free output register shows up the next cycle.
  `NSL_ASSERT(a_result_lands, (state_q == ST_RESULT && out_free) |=> (out_valid_q && state_q == ST_IDLE), "result not delivered to output")

  // No-site results always carry index zero.
  `NSL_ASSERT_NEVER(a_none_index, out_valid_q && out_none_q && (out_idx_q != '0), "none result with nonzero index")

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Nearest site labeler testbench
// Loads sites into the labeler, queries pixels under several site counts
// and checks every returned label against a shadow of the site table,
// which computes the nearest site by exact squared distance. Both sides
// idle and stall at random, and the sender drains the block at times.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_WORDS  = 1700;

  typedef enum logic [1:0] {
    ST_WORD,
    ST_CFG,
    ST_DRAIN
  } stim_kind_e;

  typedef struct {
    stim_kind_e                         kind;
    nsl_pkg::nsl_op_e                   op;
    logic [nsl_pkg::SLOT_IN_BITS-1:0]   slot;
    logic [nsl_pkg::COORD_BITS-1:0]     x;
    logic [nsl_pkg::COORD_BITS-1:0]     y;
    logic [nsl_pkg::CFG_BITS-1:0]       count;
    int                                 gap;
  } stim_t;

  typedef struct packed {
    logic [nsl_pkg::IDX_OUT_BITS-1:0] nearest_index;
    logic                             none_loaded;
  } label_t;

  // Clock, reset and block ports; every input starts at a known value
  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic                             cfg_valid_i     = 1'b0;
  logic                             cfg_ready_o;
  logic [nsl_pkg::CFG_BITS-1:0]     cfg_data_i      = '0;
  logic                             in_valid_i      = 1'b0;
  logic                             in_ready_o;
  logic                             op_i            = 1'b0;
  logic [nsl_pkg::SLOT_IN_BITS-1:0] slot_i          = '0;
  logic [nsl_pkg::COORD_BITS-1:0]   coord_x_i       = '0;
  logic [nsl_pkg::COORD_BITS-1:0]   coord_y_i       = '0;
  logic                             out_valid_o;
  logic                             out_ready_i     = 1'b0;
  logic [nsl_pkg::IDX_OUT_BITS-1:0] nearest_index_o;
  logic                             none_loaded_o;

  // Pending words for the driver, and labels still owed by the block
  stim_t       stim_q[$];
  label_t      pending_labels[$];

  // Shadow of the block state, updated as words and writes are accepted
  nsl_pkg::nsl_site_t           site_table_shadow [nsl_pkg::MAX_SITES];
  logic [nsl_pkg::CFG_BITS-1:0] site_count_shadow = '0;

  // Generator bookkeeping: what the queued stimulus will have loaded
  int          gen_count;
  logic [nsl_pkg::MAX_SITES-1:0] gen_written;
  int          gen_x [nsl_pkg::MAX_SITES];
  int          gen_y [nsl_pkg::MAX_SITES];
  bit          calm_sender;
  int          words_queued;

  int          error_count = 0;
  int          cycle_count = 0;

  // Driver state
  int          hold_cycles   = 0;
  bit          drain_pending = 1'b0;
  int          settle_left   = 0;

  always #5 clk_i = ~clk_i;

  nearest_site_labeler_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .slot_i          (slot_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .nearest_index_o (nearest_index_o),
    .none_loaded_o   (none_loaded_o)
  );

  // --------------------------------------------------------------------------
  // Nearest site computation on the shadow table
  // --------------------------------------------------------------------------

  // Store a site on a load; on a query scan the first count slots and keep
  // the least squared distance, a strict compare so the lowest index wins.
  task automatic compute_nearest_site(input nsl_pkg::nsl_op_e op,
                                      input logic [nsl_pkg::SLOT_IN_BITS-1:0] slot,
                                      input logic [nsl_pkg::COORD_BITS-1:0] px,
                                      input logic [nsl_pkg::COORD_BITS-1:0] py);
    int unsigned span;
    int unsigned dx;
    int unsigned dy;
    int unsigned sq_dist;
    int unsigned best_dist;
    int          best;
    label_t      lbl;
    if (op == nsl_pkg::OP_LOAD) begin
      site_table_shadow[slot] = '{x: px, y: py};
    end else begin
      // Counts above the table size saturate
      span = (site_count_shadow > nsl_pkg::MAX_SITES) ? nsl_pkg::MAX_SITES
                                                      : site_count_shadow;
      best = 0;
      best_dist = 0;
      for (int k = 0; k < span; k++) begin
        dx = (px > site_table_shadow[k].x) ? px - site_table_shadow[k].x
                                           : site_table_shadow[k].x - px;
        dy = (py > site_table_shadow[k].y) ? py - site_table_shadow[k].y
                                           : site_table_shadow[k].y - py;
        sq_dist = dx * dx + dy * dy;
        if (k == 0 || sq_dist < best_dist) begin
          best_dist = sq_dist;
          best = k;
        end
      end
      lbl.nearest_index = best[nsl_pkg::IDX_OUT_BITS-1:0];
      lbl.none_loaded   = (span == 0);
      pending_labels.push_back(lbl);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favor the coordinate extremes now and then
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return (1 << nsl_pkg::COORD_BITS) - 1;
    return $urandom_range(0, (1 << nsl_pkg::COORD_BITS) - 1);
  endfunction

  task automatic push_word(input nsl_pkg::nsl_op_e op, input int slot, input int x,
                           input int y);
    stim_t s;
    s.kind  = ST_WORD;
    s.op    = op;
    s.slot  = slot[nsl_pkg::SLOT_IN_BITS-1:0];
    s.x     = x[nsl_pkg::COORD_BITS-1:0];
    s.y     = y[nsl_pkg::COORD_BITS-1:0];
    s.count = '0;
    s.gap   = pick_gap(calm_sender);
    stim_q.push_back(s);
    words_queued++;
    if (op == nsl_pkg::OP_LOAD) begin
      gen_written[slot] = 1'b1;
      gen_x[slot] = x;
      gen_y[slot] = y;
    end
  endtask

  // Load any slot the search would reach before it was written, then query
  task automatic push_query(input int x, input int y);
    for (int k = 0; k < gen_count; k++) begin
      if (!gen_written[k]) push_word(nsl_pkg::OP_LOAD, k, pick_coord(), pick_coord());
    end
    push_word(nsl_pkg::OP_QUERY, $urandom_range(0, nsl_pkg::MAX_SITES - 1), x, y);
  endtask

  task automatic push_drain();
    stim_t s;
    s = '{kind: ST_DRAIN, op: nsl_pkg::OP_LOAD, slot: '0, x: '0, y: '0, count: '0,
          gap: 0};
    stim_q.push_back(s);
  endtask

  // Register writes only go out once the block has drained
  task automatic push_cfg(input int count);
    stim_t s;
    push_drain();
    s = '{kind: ST_CFG, op: nsl_pkg::OP_LOAD, slot: '0, x: '0, y: '0,
          count: count[nsl_pkg::CFG_BITS-1:0], gap: 0};
    stim_q.push_back(s);
    gen_count = (count > nsl_pkg::MAX_SITES) ? nsl_pkg::MAX_SITES : count;
  endtask

  // Two sites at equal distance from a pixel, then the query at that pixel
  task automatic push_tie_sequence();
    int a;
    int b;
    int qx;
    int qy;
    int dx;
    int dy;
    a  = $urandom_range(0, gen_count - 2);
    b  = $urandom_range(a + 1, gen_count - 1);
    qx = $urandom_range(256, 767);
    qy = $urandom_range(256, 767);
    if ($urandom_range(0, 1) == 0) begin
      dx = $urandom_range(0, 3);
      dy = $urandom_range(0, 3);
    end else begin
      dx = $urandom_range(0, 255);
      dy = $urandom_range(0, 255);
    end
    // Second site is the first rotated a quarter turn about the pixel
    push_word(nsl_pkg::OP_LOAD, a, qx + dx, qy + dy);
    push_word(nsl_pkg::OP_LOAD, b, qx - dy, qy + dx);
    push_query(qx, qy);
  endtask

  task automatic push_random_step();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      push_drain();
    end else if (r < 32) begin
      k = $urandom_range(0, nsl_pkg::MAX_SITES - 1);
      if ($urandom_range(0, 5) == 0 && gen_written != '0) begin
        // Duplicate an existing site so distances tie exactly
        r = $urandom_range(0, nsl_pkg::MAX_SITES - 1);
        while (!gen_written[r]) r = $urandom_range(0, nsl_pkg::MAX_SITES - 1);
        push_word(nsl_pkg::OP_LOAD, k, gen_x[r], gen_y[r]);
      end else begin
        push_word(nsl_pkg::OP_LOAD, k, pick_coord(), pick_coord());
      end
    end else if (r < 47 && gen_count >= 2) begin
      push_tie_sequence();
    end else if (r < 62 && gen_count >= 1) begin
      k = $urandom_range(0, gen_count - 1);
      if (gen_written[k]) push_query(gen_x[k], gen_y[k]);
      else push_query(pick_coord(), pick_coord());
    end else begin
      push_query(pick_coord(), pick_coord());
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: hold each word until accepted, then advance through the queue
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : word_driver
    logic  nxt_valid;
    logic  nxt_cfg_valid;
    stim_t s;
    if (rst_ni) begin
      nxt_valid     = in_valid_i;
      nxt_cfg_valid = cfg_valid_i;
      // Predict on acceptance so the shadow follows the block's own order
      if (in_valid_i && in_ready_o) begin
        compute_nearest_site(nsl_pkg::nsl_op_e'(op_i), slot_i, coord_x_i, coord_y_i);
        nxt_valid = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        site_count_shadow = cfg_data_i;
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_valid && !nxt_cfg_valid) begin
        if (hold_cycles > 0) begin
          hold_cycles--;
        end else if (drain_pending) begin
          // Hold until every label is back, then let the pipe settle
          if (pending_labels.size() == 0) begin
            if (settle_left == 0) drain_pending = 1'b0;
            else settle_left--;
          end
        end else if (stim_q.size() > 0) begin
          s = stim_q.pop_front();
          case (s.kind)
            ST_WORD: begin
              nxt_valid   = 1'b1;
              op_i       <= s.op;
              slot_i     <= s.slot;
              coord_x_i  <= s.x;
              coord_y_i  <= s.y;
              hold_cycles = s.gap;
            end
            ST_CFG: begin
              nxt_cfg_valid = 1'b1;
              cfg_data_i   <= s.count;
            end
            default: begin
              drain_pending = 1'b1;
              settle_left   = SETTLE_CYCLES;
            end
          endcase
        end
      end
      in_valid_i  <= nxt_valid;
      cfg_valid_i <= nxt_cfg_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure with calm stretches
  // --------------------------------------------------------------------------
  int stall_left = 0;
  int mode_left  = 0;
  bit calm_sink  = 1'b0;

  always @(posedge clk_i) begin : result_sink
    logic nxt_ready;
    if (mode_left == 0) begin
      calm_sink = ($urandom_range(0, 3) == 0);
      mode_left = $urandom_range(100, 400);
    end else begin
      mode_left--;
    end
    if (calm_sink) begin
      nxt_ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt_ready = 1'b0;
    end else if ($urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                               : $urandom_range(0, 2);
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = 1'b1;
    end
    out_ready_i <= nxt_ready;
  end

  // Compare each accepted label with the oldest one owed
  always @(posedge clk_i) begin : result_check
    label_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_labels.size() == 0) begin
        report_mismatch("unexpected result word", nearest_index_o, -1);
      end else begin
        want = pending_labels.pop_front();
        if (nearest_index_o !== want.nearest_index)
          report_mismatch("nearest_index", nearest_index_o, want.nearest_index);
        if (none_loaded_o !== want.none_loaded)
          report_mismatch("none_loaded", none_loaded_o, want.none_loaded);
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: fill the queue, release reset, wait for the last label
  // --------------------------------------------------------------------------
  initial begin : sequencer
    int phase;
    int phase_len;
    int count;
    gen_count    = 0;
    gen_written  = '0;
    words_queued = 0;
    calm_sender  = 1'b0;

    // Queries with the reset count: nothing takes part
    push_query(0, 0);
    push_query(1023, 1023);
    // Sites at the four corners, and a lone high slot outside the search
    push_word(nsl_pkg::OP_LOAD, 0, 0, 0);
    push_word(nsl_pkg::OP_LOAD, 1, 1023, 1023);
    push_word(nsl_pkg::OP_LOAD, 2, 1023, 0);
    push_word(nsl_pkg::OP_LOAD, 3, 0, 1023);
    push_word(nsl_pkg::OP_LOAD, 31, 512, 512);
    push_cfg(4);
    push_query(0, 0);
    push_query(1023, 1023);
    push_query(1023, 0);
    push_query(0, 1023);
    push_query(511, 511);
    push_query(512, 512);
    // Duplicate site: the lower slot must win the tie
    push_word(nsl_pkg::OP_LOAD, 2, 0, 0);
    push_query(5, 5);
    push_cfg(1);
    push_query(1023, 1023);
    push_cfg(0);
    push_query(300, 700);

    // Random phases, each under its own site count
    words_queued = 0;
    phase = 0;
    while (words_queued < RANDOM_WORDS) begin
      case (phase)
        0: count = 63;
        1: count = 32;
        2: count = 33;
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
              0: count = 0;
              1: count = 1;
              2: count = 2;
              3: count = 31;
              4: count = 32;
              default: count = 63;
            endcase
          end else begin
            count = $urandom_range(0, 63);
          end
        end
      endcase
      push_cfg(count);
      calm_sender = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 220);
      repeat (phase_len) push_random_step();
      phase++;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the queue to empty and the last word to be taken
    do @(posedge clk_i);
    while (stim_q.size() != 0 || in_valid_i || cfg_valid_i || drain_pending);
    while (pending_labels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
